[src/fence_retired_page_allocator_assert.svh]
`ifndef FENCE_RETIRED_PAGE_ALLOCATOR_ASSERT_SVH
`define FENCE_RETIRED_PAGE_ALLOCATOR_ASSERT_SVH
// implication checked every clock outside reset
`define FRPA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define FRPA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[src/frpa_pkg.sv]
package frpa_pkg;
    localparam int MAX_PAGES   = 16;
    localparam int PAGE_BITS   = 4;
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_BITS   = 5;
    localparam int SIZE_BITS   = 32;
    localparam logic [31:0] RESET_MIN_PAGE = 32'd4194304;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_SUBMIT  = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;
    localparam logic [1:0] OP_POLL    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOSLOT = 2'd1;
    localparam logic [1:0] ST_QFULL = 2'd2;
    localparam logic [1:0] ST_BADPG = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] alloc_size;
        logic [4:0]  align_log2;
        logic [3:0]  target_page;
        logic [31:0] completed_fence;
        logic        need_ovf;
        logic [32:0] need;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_page;
        logic [31:0] result_offset;
        logic [31:0] issued_fence;
    } rsp_t;
endpackage

[src/frpa_ram.sv]
module frpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/frpa_front.sv]
module frpa_front import frpa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] alloc_size,
    input  logic [4:0]  align_log2,
    input  logic [3:0]  target_page,
    input  logic [31:0] completed_fence,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);
    // two-entry command queue
    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    cmd_t in_cmd;
    logic [32:0] need;
    logic accept;

    assign need = {1'b0, alloc_size} + (33'd1 << align_log2) - 33'd1;
    always_comb
    begin
        in_cmd.opcode = opcode;
        in_cmd.alloc_size = alloc_size;
        in_cmd.align_log2 = align_log2;
        in_cmd.target_page = target_page;
        in_cmd.completed_fence = completed_fence;
        in_cmd.need = need;
        in_cmd.need_ovf = need[32];
    end

    assign full = (cnt_reg == 2'd2);
    assign accept = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_reg <= !wr_reg;
            end
            if (cmd_take)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, accept} - {1'b0, cmd_take};
        end
    end
endmodule

[src/frpa_back.sv]
module frpa_back import frpa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        rsp_valid,
    output rsp_t        rsp,
    input  logic        rsp_take
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RREQ = 3'd1;
    localparam logic [2:0] S_RCHK = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [31:0] min_reg;
    logic [MAX_PAGES-1:0] open_reg;
    logic [31:0] bytes_reg [MAX_PAGES];
    logic [31:0] fill_reg [MAX_PAGES];
    logic [7:0]  users_reg [MAX_PAGES];
    logic [4:0]  opened_reg;
    logic [31:0] fence_reg;
    logic [QPTR_BITS:0] head_reg, tail_reg;
    cmd_t c_reg;
    logic [PAGE_BITS:0] scan_reg;
    logic found_reg;
    logic [31:0] best_reg;
    logic [PAGE_BITS-1:0] pg_reg;
    rsp_t res_reg;
    rsp_t out_reg;
    logic full_reg;

    logic q_we;
    logic [35:0] q_wdata, q_rdata;
    logic [QPTR_BITS:0] qcount;
    logic [PAGE_BITS-1:0] si, rp, tp;
    logic [31:0] rem;
    logic [31:0] alm, offs;

    frpa_ram #(.WIDTH(36), .DEPTH(QUEUE_DEPTH)) u_relq (
        .clk(clk), .we(q_we), .waddr(tail_reg[QPTR_BITS-1:0]), .wdata(q_wdata),
        .raddr(head_reg[QPTR_BITS-1:0]), .rdata(q_rdata)
    );

    assign qcount = tail_reg - head_reg;
    assign si = scan_reg[PAGE_BITS-1:0];
    assign rp = q_rdata[3:0];
    assign tp = c_reg.target_page;
    assign rem = bytes_reg[si] - fill_reg[si];
    assign alm = (32'd1 << c_reg.align_log2) - 32'd1;
    assign offs = (fill_reg[pg_reg] + alm) & ~alm;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign rsp_valid = full_reg;
    assign rsp = out_reg;
    assign q_we = (state_reg == S_EXEC) && (c_reg.opcode == OP_SUBMIT
        || c_reg.opcode == OP_DISCARD) && open_reg[tp] && users_reg[tp] != 8'd0
        && qcount < (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign q_wdata = {(c_reg.opcode == OP_SUBMIT) ? fence_reg + 32'd1 : 32'd0, tp};

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            c_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_reg <= RESET_MIN_PAGE;
            open_reg <= '0;
            opened_reg <= '0;
            fence_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            full_reg <= 1'b0;
            scan_reg <= '0;
            found_reg <= 1'b0;
            best_reg <= '0;
            pg_reg <= '0;
            res_reg <= '0;
            out_reg <= '0;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                bytes_reg[i] <= '0;
                fill_reg[i] <= '0;
                users_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
            if (state_reg == S_OUT && (!full_reg || rsp_take))
            begin
                full_reg <= 1'b1;
            end
            else if (rsp_take)
            begin
                full_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        state_reg <= S_RREQ;
                    end
                end
                S_RREQ:
                begin
                    state_reg <= S_RCHK;
                end
                S_RCHK:
                begin
                    if (qcount != '0 && q_rdata[35:4] <= c_reg.completed_fence)
                    begin
                        head_reg <= head_reg + 1'b1;
                        if (open_reg[rp] && users_reg[rp] != 8'd0)
                        begin
                            users_reg[rp] <= users_reg[rp] - 8'd1;
                            if (users_reg[rp] == 8'd1)
                            begin
                                fill_reg[rp] <= '0;
                            end
                        end
                        state_reg <= S_RREQ;
                    end
                    else
                    begin
                        scan_reg <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (c_reg.opcode == OP_ALLOC) ? S_SCAN : S_EXEC;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg == (PAGE_BITS+1)'(MAX_PAGES))
                    begin
                        state_reg <= S_EXEC;
                    end
                    else
                    begin
                        if (open_reg[si] && users_reg[si] != 8'd255
                            && {1'b0, rem} >= c_reg.need && (!found_reg || rem < best_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= rem;
                            pg_reg <= si;
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_EXEC:
                begin
                    res_reg <= '0;
                    state_reg <= S_OUT;
                    case (c_reg.opcode)
                        OP_ALLOC:
                        begin
                            if (c_reg.need_ovf)
                            begin
                                res_reg.status <= ST_NOSLOT;
                            end
                            else if (!found_reg)
                            begin
                                if (opened_reg == 5'(MAX_PAGES))
                                begin
                                    res_reg.status <= ST_NOSLOT;
                                end
                                else
                                begin
                                    open_reg[opened_reg[3:0]] <= 1'b1;
                                    bytes_reg[opened_reg[3:0]] <=
                                        (min_reg > c_reg.need[31:0]) ? min_reg
                                                                     : c_reg.need[31:0];
                                    fill_reg[opened_reg[3:0]] <= '0;
                                    users_reg[opened_reg[3:0]] <= '0;
                                    pg_reg <= opened_reg[3:0];
                                    found_reg <= 1'b1;
                                    opened_reg <= opened_reg + 5'd1;
                                    state_reg <= S_EXEC;
                                end
                            end
                            else
                            begin
                                fill_reg[pg_reg] <= offs + c_reg.alloc_size;
                                users_reg[pg_reg] <= users_reg[pg_reg] + 8'd1;
                                res_reg.result_page <= pg_reg;
                                res_reg.result_offset <= offs;
                            end
                        end
                        OP_SUBMIT, OP_DISCARD:
                        begin
                            if (!open_reg[tp] || users_reg[tp] == 8'd0)
                            begin
                                res_reg.status <= ST_BADPG;
                            end
                            else if (!q_we)
                            begin
                                res_reg.status <= ST_QFULL;
                            end
                            else
                            begin
                                tail_reg <= tail_reg + 1'b1;
                                if (c_reg.opcode == OP_SUBMIT)
                                begin
                                    fence_reg <= fence_reg + 32'd1;
                                    res_reg.issued_fence <= fence_reg + 32'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!full_reg || rsp_take)
                    begin
                        out_reg <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[src/fence_retired_page_allocator.sv]
// channel   dir  handshake        fields
// item      in   push / full      opcode alloc_size align_log2 target_page completed_fence
// result    out  pop / empty      status result_page result_offset issued_fence
// config    in   cfg_we           cfg_wdata (min_page_size)
// An item first retires entries whose fence is done (RREQ/RCHK); an allocate then
// scans every page slot for the best fit, and a newly opened page passes through EXEC again.
// The release queue RAM (one read port) paces retirement; the page scan one slot per cycle.
// Reset clears all control; two items may wait in the front queue while one result waits.
module fence_retired_page_allocator import frpa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] alloc_size,
    input  logic [4:0]  align_log2,
    input  logic [3:0]  target_page,
    input  logic [31:0] completed_fence,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [3:0]  result_page,
    output logic [31:0] result_offset,
    output logic [31:0] issued_fence,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
`include "fence_retired_page_allocator_assert.svh"
    logic cmd_valid, cmd_take, rsp_valid, rsp_take;
    cmd_t cmd;
    rsp_t rsp;

    frpa_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .alloc_size(alloc_size), .align_log2(align_log2), .target_page(target_page),
        .completed_fence(completed_fence), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take)
    );

    frpa_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
        .rsp_valid(rsp_valid), .rsp(rsp), .rsp_take(rsp_take)
    );

    assign empty = !rsp_valid;
    assign rsp_take = pop && rsp_valid;
    assign status = rsp.status;
    assign result_page = rsp.result_page;
    assign result_offset = rsp.result_offset;
    assign issued_fence = rsp.issued_fence;

    `FRPA_ASSERT_IMP(a_take_valid, clk, rst_n, cmd_take, cmd_valid, "take without command")
    `FRPA_ASSERT_IMP(a_err_zero, clk, rst_n, !empty && status != ST_OK,
        result_offset == 32'd0 && issued_fence == 32'd0, "error result carries data")
    `FRPA_ASSERT_NEXT(a_word_hold, clk, rst_n, !empty && !pop,
        !empty && $stable({status, result_page, result_offset, issued_fence}),
        "waiting result word changed")
endmodule
